### src/pcmd_pkg.sv
// Package for the per-client message dedup block.
// Holds the field widths shared by the channels and both ends; no dependencies.
`default_nettype none
package pcmd_pkg;
   localparam int unsigned AddrWidth = 32;
   localparam int unsigned PortWidth = 16;
   localparam int unsigned IdWidth   = 32;
endpackage
`default_nettype wire

### src/pcmd_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on pcmd_pkg for field widths.
`default_nettype none
interface pcmd_req_if;
   logic                             valid;
   logic                             ready;
   logic [pcmd_pkg::AddrWidth-1:0]   sender_address;
   logic [pcmd_pkg::PortWidth-1:0]   sender_port;
   logic [pcmd_pkg::IdWidth-1:0]     message_id;
   logic                             well_formed;
   modport source (output valid, sender_address, sender_port, message_id, well_formed,
                   input ready);
   modport sink   (input valid, sender_address, sender_port, message_id, well_formed,
                   output ready);
endinterface

interface pcmd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           is_new;
   logic                           no_slot;
   logic                           has_id;
   logic [pcmd_pkg::IdWidth-1:0]   reply_id;
   logic                           last;
   modport source (output valid, is_new, no_slot, has_id, reply_id, last, input ready);
   modport sink   (input valid, is_new, no_slot, has_id, reply_id, last, output ready);
endinterface
`default_nettype wire

### src/pcmd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pcmd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### src/pcmd_front.sv
// Front end: accepts requests, matches or claims a client slot, queues a job.
// Depends on pcmd_pkg and the channel interfaces; exports slot number and count.
`default_nettype none
module pcmd_front #(
   parameter int unsigned CLIENT_SLOTS   = 16,
   parameter int unsigned IDS_PER_CLIENT = 64,
   localparam int unsigned SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1,
   localparam int unsigned CW = $clog2(IDS_PER_CLIENT + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   pcmd_req_if.sink                          req,
   // job out
   output logic                              job_valid,
   input  wire logic                         job_ready,
   output logic                              job_no_slot,
   output logic [SW-1:0]                     job_slot,
   output logic [CW-1:0]                     job_count,
   output logic [pcmd_pkg::IdWidth-1:0]      job_id,
   output logic                              job_wf,
   // count write-back from back end
   input  wire logic                         upd_en,
   input  wire logic [SW-1:0]                upd_slot,
   input  wire logic [CW-1:0]                upd_count
);
   logic [CLIENT_SLOTS-1:0]          active_ff, active_in;
   logic [pcmd_pkg::AddrWidth-1:0]   addr_ff [CLIENT_SLOTS];
   logic [pcmd_pkg::PortWidth-1:0]   port_ff [CLIENT_SLOTS];
   logic [CW-1:0]                    count_ff [CLIENT_SLOTS];
   logic                             full_ff, full_in;
   logic                             hit, free;
   logic [SW-1:0]                    hit_idx, free_idx;
   logic                             take;
   logic [pcmd_pkg::IdWidth-1:0]     id_ff;
   logic                             wf_ff, nos_ff, claim_ff;
   logic [SW-1:0]                    slot_ff;

   // one outstanding job: front holds until back takes it
   assign req.ready = !full_ff;
   assign take      = req.valid && req.ready;

   always_comb begin
      hit = 1'b0; hit_idx = '0; free = 1'b0; free_idx = '0;
      for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
         if (active_ff[i] && addr_ff[i] == req.sender_address &&
             port_ff[i] == req.sender_port) begin
            hit = 1'b1; hit_idx = SW'(i);
         end
         if (!active_ff[i]) begin
            free = 1'b1; free_idx = SW'(i);
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      full_in   = full_ff;
      if (job_valid && job_ready) full_in = 1'b0;
      if (take) begin
         full_in = 1'b1;
         if (!hit && free) active_in[free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         full_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         full_ff   <= full_in;
      end
      if (upd_en) count_ff[upd_slot] <= upd_count;
      if (take) begin
         id_ff    <= req.message_id;
         wf_ff    <= req.well_formed;
         nos_ff   <= !hit && !free;
         claim_ff <= !hit;
         slot_ff  <= hit ? hit_idx : free_idx;
         if (!hit && free) begin
            addr_ff[free_idx] <= req.sender_address;
            port_ff[free_idx] <= req.sender_port;
         end
      end
   end

   // read the count when the back takes the job, after any earlier write-back
   assign job_valid   = full_ff;
   assign job_id      = id_ff;
   assign job_wf      = wf_ff;
   assign job_no_slot = nos_ff;
   assign job_slot    = slot_ff;
   assign job_count   = claim_ff ? '0 : count_ff[slot_ff];
endmodule
`default_nettype wire

### src/pcmd_back.sv
// Back end: scans the client's id list, appends a new id, streams the reply.
// Depends on pcmd_pkg, the channel interfaces and pcmd_ram.
`default_nettype none
module pcmd_back #(
   parameter int unsigned CLIENT_SLOTS   = 16,
   parameter int unsigned IDS_PER_CLIENT = 64,
   parameter int unsigned REPLY_MAX      = 20,
   localparam int unsigned SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1,
   localparam int unsigned CW = $clog2(IDS_PER_CLIENT + 1),
   localparam int unsigned AW = $clog2(CLIENT_SLOTS * IDS_PER_CLIENT)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      job_valid,
   output logic                           job_ready,
   input  wire logic                      job_no_slot,
   input  wire logic [SW-1:0]             job_slot,
   input  wire logic [CW-1:0]             job_count,
   input  wire logic [pcmd_pkg::IdWidth-1:0] job_id,
   input  wire logic                      job_wf,
   output logic                           upd_en,
   output logic [SW-1:0]                  upd_slot,
   output logic [CW-1:0]                  upd_count,
   pcmd_rsp_if.source                     rsp
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_SCAN = 5'b00010, ST_DEC = 5'b00100,
      ST_READ = 5'b01000, ST_EMIT = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [SW-1:0]                slot_ff, slot_in;
   logic [CW-1:0]                n_ff, n_in;
   logic [CW-1:0]                k_ff, k_in;       // scan index / emit index
   logic [pcmd_pkg::IdWidth-1:0] id_ff, id_in;
   logic                         wf_ff, wf_in, seen_ff, seen_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic                         fresh_ff, fresh_in, nos_ff, nos_in;
   logic                         ov_ff, ov_in;
   logic                         ov_new_ff, ov_new_in, ov_nos_ff, ov_nos_in;
   logic                         ov_has_ff, ov_has_in, ov_last_ff, ov_last_in;
   logic [pcmd_pkg::IdWidth-1:0] ov_id_ff, ov_id_in;
   logic [CW-1:0]                list_idx;
   logic [AW-1:0]                rd_addr, wr_addr;
   logic [pcmd_pkg::IdWidth-1:0] rd_data;
   logic                         wr_en;
   logic                         ov_free;
   logic                         at_end;
   logic [CW-1:0]                n_new;

   function automatic logic [AW-1:0] ent(input logic [SW-1:0] s, input logic [CW-1:0] k);
      return AW'(s * IDS_PER_CLIENT + k);
   endfunction

   assign ov_free   = !ov_ff || rsp.ready;
   assign job_ready = (state_ff == ST_IDLE);
   assign list_idx  = (state_ff == ST_SCAN) ? k_ff : CW'(n_ff - 1'b1 - k_ff);
   assign rd_addr   = ent(slot_ff, list_idx);
   assign n_new     = n_ff + 1'b1;
   assign wr_en     = (state_ff == ST_DEC) && wf_ff && !seen_ff &&
                      (n_ff < CW'(IDS_PER_CLIENT));
   assign wr_addr   = ent(slot_ff, n_ff);
   assign upd_en    = (state_ff == ST_DEC);
   assign upd_slot  = slot_ff;
   assign upd_count = wr_en ? n_new : n_ff;
   assign at_end    = nos_ff || (n_ff == '0) || (k_ff + 1'b1 == n_ff) ||
                      (int'(k_ff) + 1 == int'(REPLY_MAX));

   pcmd_ram #(.WIDTH(pcmd_pkg::IdWidth), .DEPTH(CLIENT_SLOTS * IDS_PER_CLIENT)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(id_ff),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      id_in      = id_ff;
      wf_in      = wf_ff;
      seen_in    = seen_ff;
      fresh_in   = fresh_ff;
      nos_in     = nos_ff;
      rd_pend_in = 1'b0;
      ov_in      = ov_ff;
      ov_new_in  = ov_new_ff;
      ov_nos_in  = ov_nos_ff;
      ov_has_in  = ov_has_ff;
      ov_id_in   = ov_id_ff;
      ov_last_in = ov_last_ff;
      if (rsp.valid && rsp.ready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               slot_in = job_slot; n_in = job_count; id_in = job_id;
               wf_in = job_wf; nos_in = job_no_slot; seen_in = 1'b0;
               k_in = '0; fresh_in = 1'b0;
               state_in = job_no_slot ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_pend_ff && rd_data == id_ff) seen_in = 1'b1;
            if (k_ff < n_ff && wf_ff) begin
               k_in = k_ff + 1'b1; rd_pend_in = 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            fresh_in = wf_ff && !seen_ff;
            if (wr_en) n_in = n_new;
            k_in     = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            rd_pend_in = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (ov_free && (rd_pend_ff || nos_ff || n_ff == '0)) begin
               ov_in      = 1'b1;
               ov_new_in  = fresh_ff;
               ov_nos_in  = nos_ff;
               ov_has_in  = !nos_ff && (n_ff != '0);
               ov_id_in   = (!nos_ff && (n_ff != '0)) ? rd_data : '0;
               ov_last_in = at_end;
               if (at_end) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               rd_pend_in = rd_pend_ff;  // keep read data, address unchanged
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ov_ff      <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ov_ff      <= ov_in;
         rd_pend_ff <= rd_pend_in;
      end
      slot_ff    <= slot_in;
      n_ff       <= n_in;
      k_ff       <= k_in;
      id_ff      <= id_in;
      wf_ff      <= wf_in;
      seen_ff    <= seen_in;
      fresh_ff   <= fresh_in;
      nos_ff     <= nos_in;
      ov_new_ff  <= ov_new_in;
      ov_nos_ff  <= ov_nos_in;
      ov_has_ff  <= ov_has_in;
      ov_id_ff   <= ov_id_in;
      ov_last_ff <= ov_last_in;
   end

   assign rsp.valid    = ov_ff;
   assign rsp.is_new   = ov_new_ff;
   assign rsp.no_slot  = ov_nos_ff;
   assign rsp.has_id   = ov_has_ff;
   assign rsp.reply_id = ov_id_ff;
   assign rsp.last     = ov_last_ff;
endmodule
`default_nettype wire

### src/per_client_message_dedup.sv
// Top level of the per-client message dedup block.
// Depends on pcmd_pkg, the channel interfaces, pcmd_front, pcmd_back, pcmd_ram.
//
// req: one received message (sender address, port, message id, well-formed).
// rsp: the reply stream; last marks the final item of one message.
// The front matches the sender against all CLIENT_SLOTS slots combinationally
// and hands one job to the back. The back reads the client's id list from a
// RAM, one entry a cycle, to find duplicates, appends a well-formed new id
// when the list has room, then reads and sends the newest ids, newest first,
// max(1, min(n', REPLY_MAX)) items for n' ids (one item for no_slot). The
// RAM's single read port serves both the scan and the reply. The front takes
// the next message while the back is still replying.
// Reset (synchronous) frees every slot; the id RAM needs no clearing.
// When rsp stalls, the output register holds and the back waits.
`default_nettype none
module per_client_message_dedup #(
   parameter int unsigned CLIENT_SLOTS   = 16,
   parameter int unsigned IDS_PER_CLIENT = 64,
   parameter int unsigned REPLY_MAX      = 20
) (
   input  wire logic  clock,
   input  wire logic  reset,
   pcmd_req_if.sink   req,
   pcmd_rsp_if.source rsp
);
   localparam int unsigned SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
   localparam int unsigned CW = $clog2(IDS_PER_CLIENT + 1);

   logic                         job_valid, job_ready, job_no_slot, job_wf, upd_en;
   logic [SW-1:0]                job_slot, upd_slot;
   logic [CW-1:0]                job_count, upd_count;
   logic [pcmd_pkg::IdWidth-1:0] job_id;

   pcmd_front #(.CLIENT_SLOTS(CLIENT_SLOTS), .IDS_PER_CLIENT(IDS_PER_CLIENT)) u_front (
      .clock, .reset, .req, .job_valid, .job_ready, .job_no_slot, .job_slot,
      .job_count, .job_id, .job_wf, .upd_en, .upd_slot, .upd_count
   );

   pcmd_back #(.CLIENT_SLOTS(CLIENT_SLOTS), .IDS_PER_CLIENT(IDS_PER_CLIENT),
               .REPLY_MAX(REPLY_MAX)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job_no_slot, .job_slot,
      .job_count, .job_id, .job_wf, .upd_en, .upd_slot, .upd_count, .rsp
   );

   a_noslot_alone: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.no_slot |-> rsp.last && !rsp.has_id && !rsp.is_new)
      else $error("no_slot item carries data");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.has_id |-> rsp.reply_id == '0 && rsp.last)
      else $error("empty reply malformed");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.reply_id))
      else $error("stalled reply changed");
endmodule
`default_nettype wire
